>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

>>> rtl/crss_pkg.sv
`default_nettype none

package crss_pkg;

	// Default sample width and the coil count at which the sum saturates.
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_COILS_DEF   = 32;

	// Fixed widths of the result fields.
	localparam int MAG_W       = 19;
	localparam int OUT_TDATA_W = 24;

	// Coil counter: six bits, saturating at its top value.
	localparam int COUNT_W = 6;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Control that travels with each request along the root cells.
	typedef struct packed {
		logic valid;
		logic too_few;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/crss_cell.sv
`default_nettype none

module crss_cell import crss_pkg::*; #(
	parameter int SUM_W  = 37,
	parameter int ROOT_W = 19,
	parameter int STEP   = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        in_ctl,
	input  wire logic [SUM_W-1:0] in_rem,
	input  wire logic [SUM_W-1:0] in_root,
	input  wire logic             rdy_next,
	output logic                  rdy,
	output cell_ctl_t             out_ctl,
	output logic [SUM_W-1:0]      out_rem,
	output logic [SUM_W-1:0]      out_root
);

	// Weight of the root bit that this cell decides.
	localparam logic [SUM_W-1:0] BIT_W =
		{{(SUM_W-1){1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - STEP));

	logic             valid_q;
	logic             few_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-1:0] trial;
	logic             take;
	logic [SUM_W-1:0] rem_d;
	logic [SUM_W-1:0] root_d;

	// One step of the digit-by-digit square root.
	always_comb begin
		trial = in_root + BIT_W;
		take  = (in_rem >= trial);
		if (take) begin
			rem_d  = in_rem - trial;
			root_d = (in_root >> 1) + BIT_W;
		end else begin
			rem_d  = in_rem;
			root_d = in_root >> 1;
		end
	end

	// The cell takes a new request when empty or when its neighbour moves on.
	assign rdy = !valid_q || rdy_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rdy) begin
			valid_q <= in_ctl.valid;
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (rdy && in_ctl.valid) begin
			rem_q  <= rem_d;
			root_q <= root_d;
			few_q  <= in_ctl.too_few;
		end
	end

	assign out_ctl.valid   = valid_q;
	assign out_ctl.too_few = few_q;
	assign out_rem         = rem_q;
	assign out_root        = root_q;

endmodule

`default_nettype wire

>>> rtl/crss_front.sv
`default_nettype none

module crss_front import crss_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_COILS   = MAX_COILS_DEF,
	parameter int SUM_W       = 37
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] coil_real,
	input  wire logic signed [SAMPLE_BITS-1:0] coil_imag,
	input  wire logic                          last_coil,
	input  wire logic                          chain_rdy,
	output cell_ctl_t                          sum_ctl,
	output logic [SUM_W-1:0]                   sum_val
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	// Largest sum that MAX_COILS full-scale samples can give.
	localparam logic [SUM_W-1:0] SUM_CAP =
		SUM_W'(MAX_COILS * 2) << (2 * (SAMPLE_BITS - 1));

	logic signed [SQ_W-1:0] re_prod;
	logic signed [SQ_W-1:0] im_prod;

	logic             v_s1;
	logic             last_s1;
	logic [SQ_W-1:0]  re_sq_s1;
	logic [SQ_W-1:0]  im_sq_s1;
	logic             v_s2;
	logic             last_s2;
	logic [SQ_W-1:0]  pwr_s2;
	logic             v_s3;
	logic             few_s3;
	logic [SUM_W-1:0] sum_s3;

	logic [SUM_W-1:0]   power_sum_q;
	logic [COUNT_W-1:0] coils_q;
	logic [SUM_W:0]     raw_sum;
	logic [SUM_W-1:0]   new_sum;

	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic eat2;

	// Stage readiness: a stage-two sample closing no voxel never waits on the cells.
	assign rdy3     = !v_s3 || chain_rdy;
	assign rdy2     = !v_s2 || !last_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign eat2     = v_s2 && rdy2;

	// Squares of both parts; the product of a value with itself is never negative.
	assign re_prod = coil_real * coil_real;
	assign im_prod = coil_imag * coil_imag;

	// Running sum, clamped at the cap.
	always_comb begin
		raw_sum = {1'b0, power_sum_q} + (SUM_W + 1)'(pwr_s2);
		if (raw_sum > {1'b0, SUM_CAP}) begin
			new_sum = SUM_CAP;
		end else begin
			new_sum = raw_sum[SUM_W-1:0];
		end
	end

	// Valid flags of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= eat2 && last_s2;
			end
		end
	end

	// Accumulator and coil count, cleared at the end of each voxel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_sum_q <= '0;
			coils_q     <= '0;
		end else if (eat2) begin
			if (last_s2) begin
				power_sum_q <= '0;
				coils_q     <= '0;
			end else begin
				power_sum_q <= new_sum;
				if (coils_q != COUNT_MAX) begin
					coils_q <= coils_q + 1'b1;
				end
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			re_sq_s1 <= re_prod;
			im_sq_s1 <= im_prod;
			last_s1  <= last_coil;
		end
		if (rdy2 && v_s1) begin
			pwr_s2  <= re_sq_s1 + im_sq_s1;
			last_s2 <= last_s1;
		end
		if (rdy3 && eat2 && last_s2) begin
			sum_s3 <= new_sum;
			few_s3 <= (coils_q == '0);
		end
	end

	assign sum_ctl.valid   = v_s3;
	assign sum_ctl.too_few = few_s3;
	assign sum_val         = sum_s3;

endmodule

`default_nettype wire

>>> rtl/coil_root_sum_of_squares_top.sv
// Root-sum-of-squares coil combination.
// Input stream (s_*): one complex coil sample per request, real part in
// s_tdata[SAMPLE_BITS-1:0], imaginary part above it; s_tlast marks the last
// coil of a voxel. All coils of a voxel arrive together.
// Output stream (m_*): one request per voxel, the floor square root of the
// summed squared magnitudes in m_tdata[18:0] and, in m_tuser, a flag that is
// set when the voxel had fewer than two coils.
// Throughput: one sample per cycle while the receiver does not stall, and one
// voxel per cycle when every sample closes a voxel. The square root is a row
// of ROOT_W cells, one root bit each; the last cell is the output register.
// The sum saturates at the largest value that MAX_COILS full-scale samples
// give. Reset empties the pipeline and clears the running sum and count.
// When the receiver stalls, results queue in the root cells; samples that
// close no voxel are still taken, and s_tready falls only once a closing
// sample cannot move on into the cells.
`default_nettype none

module coil_root_sum_of_squares_top import crss_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_COILS   = MAX_COILS_DEF,
	parameter int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_W-1:0]     s_tdata,  // coil_real, coil_imag, zero fill
	input  wire logic                   s_tlast,  // last_coil
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // magnitude, zero fill
	output logic                        m_tuser   // too_few_coils
);

	localparam int SUM_W  = $clog2(MAX_COILS * 2) + 2 * (SAMPLE_BITS - 1) + 1;
	localparam int ROOT_W = (SUM_W + 1) / 2;

	logic signed [SAMPLE_BITS-1:0] coil_real;
	logic signed [SAMPLE_BITS-1:0] coil_imag;
	logic [MAG_W-1:0]              magnitude;
	logic [MAG_W+SUM_W-1:0]        root_wide;

	cell_ctl_t        ctl  [0:ROOT_W];
	logic [SUM_W-1:0] rem  [0:ROOT_W];
	logic [SUM_W-1:0] root [0:ROOT_W];
	logic             rdy  [0:ROOT_W];

	assign coil_real = s_tdata[SAMPLE_BITS-1:0];
	assign coil_imag = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

	// Squares and running sum.
	crss_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_COILS  (MAX_COILS),
		.SUM_W      (SUM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.coil_real(coil_real),
		.coil_imag(coil_imag),
		.last_coil(s_tlast),
		.chain_rdy(rdy[0]),
		.sum_ctl  (ctl[0]),
		.sum_val  (rem[0])
	);

	assign root[0] = '0;

	// Row of root cells, most significant root bit first.
	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		crss_cell #(
			.SUM_W (SUM_W),
			.ROOT_W(ROOT_W),
			.STEP  (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_ctl  (ctl[i]),
			.in_rem  (rem[i]),
			.in_root (root[i]),
			.rdy_next(rdy[i+1]),
			.rdy     (rdy[i]),
			.out_ctl (ctl[i+1]),
			.out_rem (rem[i+1]),
			.out_root(root[i+1])
		);
	end

	// The last cell is the output register.
	assign rdy[ROOT_W] = m_tready;
	assign root_wide   = {{MAG_W{1'b0}}, root[ROOT_W]};
	assign magnitude   = root_wide[MAG_W-1:0];

	assign m_tvalid = ctl[ROOT_W].valid;
	assign m_tuser  = ctl[ROOT_W].too_few;
	assign m_tdata  = {{(OUT_TDATA_W-MAG_W){1'b0}}, magnitude};

endmodule

`default_nettype wire

>>> rtl/crss_checker.sv
`default_nettype none

`include "assert_macros.svh"

module crss_checker import crss_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [TDATA_W-1:0]     s_tdata,
	input wire logic                   s_tlast,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tuser
);

	logic [7:0] pending_q;
	logic       in_close;
	logic       out_take;

	assign in_close = s_tvalid && s_tready && s_tlast;
	assign out_take = m_tvalid && m_tready;

	// Voxels closed at the input whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_close && !out_take) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_take && !in_close) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A waiting input request keeps its contents until it is taken.
	`ASSERT_STD(a_in_hold, s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast), "input changed while waiting")

	// A stalled result holds its value.
	`ASSERT_STD(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")

	// Every result belongs to a voxel closed earlier.
	`ASSERT_STD(a_no_spurious, m_tvalid |-> pending_q != 8'd0, "result without a closed voxel")

	// With no voxel in flight nothing can hold back the input.
	`ASSERT_STD(a_ready_when_clear, pending_q == 8'd0 |-> s_tready, "input stalled with no result pending")

endmodule

bind coil_root_sum_of_squares_top crss_checker #(
	.SAMPLE_BITS(SAMPLE_BITS),
	.TDATA_W    (TDATA_W)
) u_crss_checker (.*);

`default_nettype wire

>>> tb/sv/coil_root_sum_of_squares_top_tb.sv
`default_nettype none

module coil_root_sum_of_squares_top_tb;
	import crss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int S_TDATA_W = 2 * SAMPLE_BITS_DEF;

	// Largest sum that MAX_COILS full-scale samples can give; the block saturates here.
	localparam longint unsigned SUM_CAP =
		64'(MAX_COILS_DEF) * 2 * (64'd1 << (2 * SAMPLE_BITS_DEF - 2));

	// The tail wait leaves a good margin over the result latency.
	localparam int TAIL_CYCLES  = 40;
	localparam int STALL_LIMIT  = 5000;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] coil_part_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             too_few_coils;
	} voxel_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;  // coil_real, coil_imag
	logic                   s_tlast = 1'b0; // last_coil
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // magnitude, zero fill
	logic                   m_tuser;        // too_few_coils

	// Predictor state: running power sum and coil count of the open voxel.
	longint unsigned        voxel_power_sum = 0;
	logic [COUNT_W-1:0]     voxel_coil_count = '0;
	voxel_result_t          voxel_results_q[$];
	voxel_result_t          oldest_result;

	int                     src_idle_pct = 0;
	int                     snk_idle_pct = 0;
	int                     samples_sent = 0;
	int                     mismatch_count = 0;
	int                     quiet_cycles = 0;

	coil_root_sum_of_squares_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Floor square root, one result bit at a time from the top.
	function automatic logic [MAG_W-1:0] floor_root(input longint unsigned n);
		logic [MAG_W-1:0] root;
		logic [MAG_W-1:0] trial;
		root = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = root | (MAG_W'(1) << b);
			if (64'(trial) * 64'(trial) <= n)
				root = trial;
		end
		return root;
	endfunction

	// Adds one accepted sample to the open voxel and closes it on the last coil.
	function automatic void accumulate_coil(input coil_part_t re, input coil_part_t im,
			input logic last);
		longint        re_l;
		longint        im_l;
		longint unsigned power;
		voxel_result_t closed;
		re_l  = re;
		im_l  = im;
		power = re_l * re_l + im_l * im_l;
		if (voxel_power_sum > SUM_CAP || power > SUM_CAP - voxel_power_sum)
			voxel_power_sum = SUM_CAP;
		else
			voxel_power_sum += power;
		if (voxel_coil_count != COUNT_MAX)
			voxel_coil_count++;
		if (last) begin
			closed.magnitude     = floor_root(voxel_power_sum);
			closed.too_few_coils = (voxel_coil_count < 2);
			voxel_results_q.push_back(closed);
			voxel_power_sum  = 0;
			voxel_coil_count = '0;
		end
	endfunction

	// Mostly full-range values, with the extremes and small values well represented.
	function automatic coil_part_t pick_part();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return coil_part_t'(int'($urandom_range(0, 15)) - 8);
			default: return coil_part_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("%0t ns: %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// Offers one sample, idling at random first, and waits for its request to be taken.
	task automatic send_coil(input coil_part_t re, input coil_part_t im, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {im, re};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		accumulate_coil(re, im, last);
		samples_sent++;
	endtask

	// Extremes of both parts, single-coil voxels, zero power and alternating bit patterns.
	task automatic test_field_extremes();
		send_coil(16'sh8000, 16'sh8000, 1'b1);
		send_coil(16'sh7fff, 16'sh7fff, 1'b1);
		send_coil('0, '0, 1'b1);
		send_coil(16'sh8000, '0, 1'b1);
		send_coil(16'sh8000, 16'sh7fff, 1'b0);
		send_coil(16'sh7fff, 16'sh8000, 1'b1);
		send_coil('0, '0, 1'b0);
		send_coil('0, '0, 1'b1);
		send_coil(16'sh0001, '0, 1'b0);
		send_coil('0, 16'sh0001, 1'b0);
		send_coil(-16'sh0001, -16'sh0001, 1'b1);
		send_coil('0, 16'sh8000, 1'b0);
		send_coil(16'sh3039, -16'sh5ba0, 1'b1);
		send_coil(16'sh5555, 16'shaaaa, 1'b1);
		send_coil(16'shaaaa, 16'sh5555, 1'b0);
		send_coil(16'shffff, 16'sh0000, 1'b1);
	endtask

	// Full-scale voxels at the cap, just past it, and past the coil counter's top.
	task automatic test_sum_saturation();
		for (int c = 1; c <= MAX_COILS_DEF; c++)
			send_coil(16'sh8000, 16'sh8000, c == MAX_COILS_DEF);
		for (int c = 1; c <= MAX_COILS_DEF + 1; c++)
			send_coil(16'sh8000, 16'sh8000, c == MAX_COILS_DEF + 1);
		for (int c = 1; c <= 70; c++)
			send_coil(16'sh8000, 16'sh7fff, c == 70);
		for (int c = 1; c <= 64; c++)
			send_coil(pick_part(), pick_part(), c == 64);
	endtask

	// Well-formed voxels of random size and content; most are small, a few very large.
	task automatic test_random_voxels(input int n_samples);
		int target;
		int coils;
		target = samples_sent + n_samples;
		while (samples_sent < target) begin
			if ($urandom_range(19) == 0)
				coils = $urandom_range(20, 70);
			else
				coils = $urandom_range(1, 8);
			for (int c = 1; c <= coils; c++)
				send_coil(pick_part(), pick_part(), c == coils);
		end
	endtask

	// Receiver back-pressure.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Each result request is checked against the oldest expected voxel.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (voxel_results_q.size() == 0) begin
				report_mismatch("result with none expected, magnitude", 64'd0,
					64'(m_tdata[MAG_W-1:0]));
			end else begin
				oldest_result = voxel_results_q.pop_front();
				if (m_tdata[MAG_W-1:0] !== oldest_result.magnitude)
					report_mismatch("magnitude", 64'(oldest_result.magnitude),
						64'(m_tdata[MAG_W-1:0]));
				if (m_tuser !== oldest_result.too_few_coils)
					report_mismatch("too_few_coils", 64'(oldest_result.too_few_coils),
						64'(m_tuser));
			end
		end
	end

	// Ends the run if no request moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("coil_root_sum_of_squares_top verification failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		src_idle_pct = 38;
		snk_idle_pct = 47;
		test_field_extremes();
		test_random_voxels(480);

		src_idle_pct = 47;
		snk_idle_pct = 38;
		test_sum_saturation();
		test_random_voxels(480);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_voxels(480);

		@(negedge clk);
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Drain, then give any stray result time to show up.
		while (voxel_results_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && voxel_results_q.size() == 0)
			$display("coil_root_sum_of_squares_top verification clean");
		else
			$display("coil_root_sum_of_squares_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> coil_root_sum_of_squares_top.f
+incdir+rtl
rtl/crss_pkg.sv
rtl/crss_cell.sv
rtl/crss_front.sv
rtl/coil_root_sum_of_squares_top.sv
rtl/crss_checker.sv
tb/sv/coil_root_sum_of_squares_top_tb.sv
